### sv/mce_pkg.sv
// mce_pkg: shared types, codes and helper functions for the multi-checksum engine.
// No dependencies; mce_front, mce_queue, mce_back, the top level and the testbench import it.
`default_nettype none

package mce_pkg;

   // Algorithm codes held in the configuration register
   localparam logic [2:0] ALG_NONE      = 3'd0;
   localparam logic [2:0] ALG_FLETCHER  = 3'd1;
   localparam logic [2:0] ALG_ADLER     = 3'd2;
   localparam logic [2:0] ALG_CRC       = 3'd3;
   localparam logic [2:0] ALG_XOR       = 3'd4;

   // Request operation codes
   localparam logic [1:0] OP_START  = 2'd0;
   localparam logic [1:0] OP_DATA   = 2'd1;
   localparam logic [1:0] OP_FINISH = 2'd2;

   // Response status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_REFUSED = 2'd1;
   localparam logic [1:0] STATUS_SMALL   = 2'd2;

   // Arithmetic constants
   localparam logic [8:0]  FLETCHER_MOD = 9'd255;
   localparam logic [16:0] ADLER_MOD    = 17'd65521;
   localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;

   // Default depth of the command queue between front and back
   localparam int MCE_QUEUE_DEPTH = 2;

   // Work the back end performs for one request
   typedef enum logic [1:0] {
      ACT_NOP,
      ACT_CLEAR,
      ACT_ABSORB,
      ACT_REPORT
   } mce_action_type;

   // Classified request handed from front to back
   typedef struct packed {
      mce_action_type action;
      logic [2:0]     algorithm;
      logic [7:0]     data_byte;
      logic [1:0]     status;
      logic [2:0]     digest_length;
   } mce_cmd_type;

   // Digest length in bytes per algorithm
   function automatic logic [2:0] digest_len(input logic [2:0] alg);
      logic [2:0] len;
      unique case (alg)
         ALG_FLETCHER: len = 3'd2;
         ALG_ADLER:    len = 3'd4;
         ALG_CRC:      len = 3'd4;
         ALG_XOR:      len = 3'd1;
         default:      len = 3'd0;
      endcase
      return len;
   endfunction

   // One byte of reflected CRC-32, eight bit steps
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### sv/mce_req_if.sv
// mce_req_if: request channel of the multi-checksum engine (valid/ready plus payload).
// Depends on nothing.
`default_nettype none

interface mce_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] data_byte;
   logic [6:0] buffer_capacity;

   modport source (output valid, output operation, output data_byte,
                   output buffer_capacity, input ready);
   modport sink   (input valid, input operation, input data_byte,
                   input buffer_capacity, output ready);
endinterface

`default_nettype wire

### sv/mce_rsp_if.sv
// mce_rsp_if: response channel of the multi-checksum engine (valid/ready plus payload).
// Depends on nothing.
`default_nettype none

interface mce_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] digest_value;
   logic [2:0]  digest_length;

   modport source (output valid, output status, output digest_value,
                   output digest_length, input ready);
   modport sink   (input valid, input status, input digest_value,
                   input digest_length, output ready);
endinterface

`default_nettype wire

### sv/mce_front.sv
// mce_front: accepts requests, holds the algorithm register and the lifecycle stage,
// and classifies each request into a command. Depends on mce_pkg and mce_req_if.
`default_nettype none

module mce_front (
   input  wire logic         clock,
   input  wire logic         reset,
   mce_req_if.sink           req_chan,
   input  wire logic         csr_write_enable,
   input  wire logic [2:0]   csr_write_data,
   output logic              push_valid,
   input  wire logic         push_ready,
   output mce_pkg::mce_cmd_type push_data
);
   import mce_pkg::*;

   typedef enum logic [1:0] {
      STAGE_NONE,
      STAGE_INIT,
      STAGE_UPDATE,
      STAGE_FINAL
   } stage_type;

   logic [2:0]  algorithm_ff;
   stage_type   stage_ff;
   stage_type   stage_in;
   logic        accept;
   logic        alg_ok;
   logic [2:0]  need;
   mce_cmd_type cmd;

   assign accept     = req_chan.valid && push_ready;
   assign req_chan.ready = push_ready;
   assign push_valid = req_chan.valid;
   assign push_data  = cmd;

   assign alg_ok = (algorithm_ff <= ALG_XOR);
   assign need   = digest_len(algorithm_ff);

   // Classify the request and work out the next stage
   always_comb begin
      cmd.action        = ACT_NOP;
      cmd.algorithm     = algorithm_ff;
      cmd.data_byte     = req_chan.data_byte;
      cmd.status        = STATUS_REFUSED;
      cmd.digest_length = 3'd0;
      stage_in          = stage_ff;
      unique case (req_chan.operation)
         OP_START: begin
            cmd.action = ACT_CLEAR;
            if (alg_ok) begin
               cmd.status = STATUS_OK;
               stage_in   = STAGE_INIT;
            end else begin
               stage_in   = STAGE_NONE;
            end
         end
         OP_DATA: begin
            if ((stage_ff == STAGE_INIT || stage_ff == STAGE_UPDATE) &&
                alg_ok && algorithm_ff != ALG_NONE) begin
               cmd.action = ACT_ABSORB;
               cmd.status = STATUS_OK;
               stage_in   = STAGE_UPDATE;
            end
         end
         OP_FINISH: begin
            if (stage_ff != STAGE_NONE && alg_ok) begin
               if ({4'd0, need} > req_chan.buffer_capacity) begin
                  cmd.status = STATUS_SMALL;
               end else begin
                  cmd.action        = ACT_REPORT;
                  cmd.status        = STATUS_OK;
                  cmd.digest_length = need;
                  stage_in          = STAGE_FINAL;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Algorithm register and lifecycle stage
   always_ff @(posedge clock) begin
      if (reset) begin
         algorithm_ff <= ALG_NONE;
         stage_ff     <= STAGE_NONE;
      end else begin
         if (csr_write_enable) begin
            algorithm_ff <= csr_write_data;
         end
         if (accept) begin
            stage_ff <= stage_in;
         end
      end
   end

endmodule

`default_nettype wire

### sv/mce_queue.sv
// mce_queue: small command FIFO between the front and back ends.
// Depends on mce_pkg for the command type.
`default_nettype none

module mce_queue #(
   parameter int DEPTH = mce_pkg::MCE_QUEUE_DEPTH
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push_valid,
   output logic              push_ready,
   input  wire mce_pkg::mce_cmd_type push_data,
   output logic              pop_valid,
   input  wire logic         pop_ready,
   output mce_pkg::mce_cmd_type pop_data
);
   import mce_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mce_cmd_type      mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

### sv/mce_back.sv
// mce_back: runs commands against the checksum accumulators and drives the response register.
// Depends on mce_pkg and mce_rsp_if.
`default_nettype none

module mce_back (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         pop_valid,
   output logic              pop_ready,
   input  wire mce_pkg::mce_cmd_type pop_data,
   mce_rsp_if.source         rsp_chan
);
   import mce_pkg::*;

   logic [7:0]  fl_low_ff,  fl_low_in;
   logic [7:0]  fl_high_ff, fl_high_in;
   logic [15:0] adler_a_ff, adler_a_in;
   logic [15:0] adler_b_ff, adler_b_in;
   logic [31:0] crc_ff,     crc_in;
   logic [7:0]  xor_ff,     xor_in;

   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff;
   logic [31:0] rsp_value_ff;
   logic [2:0]  rsp_length_ff;
   logic [31:0] value;

   logic        take;
   logic [8:0]  fl_low_sum, fl_high_sum;
   logic [7:0]  fl_low_new;
   logic [16:0] ad_a_sum, ad_b_sum;
   logic [15:0] ad_a_new;

   assign pop_ready = !rsp_valid_ff || rsp_chan.ready;
   assign take      = pop_valid && pop_ready;

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.digest_value  = rsp_value_ff;
   assign rsp_chan.digest_length = rsp_length_ff;

   // Fletcher-16: add then one conditional subtract of 255
   assign fl_low_sum  = {1'b0, fl_low_ff} + {1'b0, pop_data.data_byte};
   assign fl_low_new  = (fl_low_sum >= FLETCHER_MOD) ? 8'(fl_low_sum - FLETCHER_MOD)
                                                     : fl_low_sum[7:0];
   assign fl_high_sum = {1'b0, fl_high_ff} + {1'b0, fl_low_new};

   // Adler-32: same trick with 65521
   assign ad_a_sum = {1'b0, adler_a_ff} + {9'd0, pop_data.data_byte};
   assign ad_a_new = (ad_a_sum >= ADLER_MOD) ? 16'(ad_a_sum - ADLER_MOD) : ad_a_sum[15:0];
   assign ad_b_sum = {1'b0, adler_b_ff} + {1'b0, ad_a_new};

   // Next accumulator values
   always_comb begin
      fl_low_in  = fl_low_ff;
      fl_high_in = fl_high_ff;
      adler_a_in = adler_a_ff;
      adler_b_in = adler_b_ff;
      crc_in     = crc_ff;
      xor_in     = xor_ff;
      unique case (pop_data.action)
         ACT_CLEAR: begin
            fl_low_in  = 8'd0;
            fl_high_in = 8'd0;
            adler_a_in = 16'd1;
            adler_b_in = 16'd0;
            crc_in     = '1;
            xor_in     = 8'd0;
         end
         ACT_ABSORB: begin
            priority case (pop_data.algorithm)
               ALG_FLETCHER: begin
                  fl_low_in  = fl_low_new;
                  fl_high_in = (fl_high_sum >= FLETCHER_MOD) ?
                               8'(fl_high_sum - FLETCHER_MOD) : fl_high_sum[7:0];
               end
               ALG_ADLER: begin
                  adler_a_in = ad_a_new;
                  adler_b_in = (ad_b_sum >= ADLER_MOD) ?
                               16'(ad_b_sum - ADLER_MOD) : ad_b_sum[15:0];
               end
               ALG_CRC: crc_in = crc_byte(crc_ff, pop_data.data_byte);
               default: xor_in = xor_ff ^ pop_data.data_byte;
            endcase
         end
         default: begin
         end
      endcase
   end

   // Digest value for a report
   always_comb begin
      value = 32'd0;
      if (pop_data.action == ACT_REPORT) begin
         unique case (pop_data.algorithm)
            ALG_FLETCHER: value = {16'd0, fl_high_ff, fl_low_ff};
            ALG_ADLER:    value = {adler_b_ff, adler_a_ff};
            ALG_CRC:      value = ~crc_ff;
            ALG_XOR:      value = {24'd0, xor_ff};
            default:      value = 32'd0;
         endcase
      end
   end

   // Accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         fl_low_ff  <= 8'd0;
         fl_high_ff <= 8'd0;
         adler_a_ff <= 16'd1;
         adler_b_ff <= 16'd0;
         crc_ff     <= '1;
         xor_ff     <= 8'd0;
      end else if (take) begin
         fl_low_ff  <= fl_low_in;
         fl_high_ff <= fl_high_in;
         adler_a_ff <= adler_a_in;
         adler_b_ff <= adler_b_in;
         crc_ff     <= crc_in;
         xor_ff     <= xor_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_status_ff <= pop_data.status;
         rsp_value_ff  <= value;
         rsp_length_ff <= pop_data.digest_length;
      end
   end

endmodule

`default_nettype wire

### sv/multi_checksum_engine.sv
// Checksum engine that runs Fletcher-16, Adler-32, CRC-32 or XOR-8 over a byte stream
// with a start / data / finish request lifecycle. One request enters per clock while
// req_chan.ready is high, and every request yields exactly one response, held first in
// the command queue and then in the response register. The back end updates the
// accumulators as each command is popped; the sustained rate is one request per cycle
// unless the response side stalls. A stalled response side backs up through the
// queue to req_chan.ready. The algorithm register is read by the front end as each
// request is classified, so it should be written only while no request is in flight.
// Depends on mce_pkg, mce_req_if, mce_rsp_if, mce_front, mce_queue and mce_back.
`default_nettype none

module multi_checksum_engine #(
   parameter int QUEUE_DEPTH = mce_pkg::MCE_QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   mce_req_if.sink         req_chan,
   mce_rsp_if.source       rsp_chan,
   input  wire logic       csr_write_enable,
   input  wire logic [2:0] csr_write_data
);
   import mce_pkg::*;

   logic        push_valid;
   logic        push_ready;
   mce_cmd_type push_data;
   logic        pop_valid;
   logic        pop_ready;
   mce_cmd_type pop_data;

   // Classification of requests
   mce_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_data        (push_data)
   );

   // Command queue
   mce_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Accumulators and response
   mce_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

### tb/sv/multi_checksum_engine_test.sv
// Self-checking testbench for multi_checksum_engine: drives start, data and finish requests
// with random gaps and stalls, and predicts every response in its own checksum model.
// Depends on mce_pkg, mce_req_if, mce_rsp_if and the engine RTL.
`timescale 1ns / 1ps

module multi_checksum_engine_test;
   import mce_pkg::*;

   // Operation code the engine has to refuse
   localparam logic [1:0] OP_UNKNOWN = 2'd3;
   // Highest algorithm code, left undefined
   localparam logic [2:0] ALG_INVALID = 3'd7;
   localparam int RANDOM_REQUESTS = 1500;

   typedef enum logic [1:0] {
      STAGE_IDLE,
      STAGE_OPEN,
      STAGE_UPDATE,
      STAGE_FINAL
   } digest_stage_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] digest_value;
      logic [2:0]  digest_length;
   } digest_reply_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write_enable;
   logic [2:0] csr_write_data;

   mce_req_if req_chan ();
   mce_rsp_if rsp_chan ();

   multi_checksum_engine dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // Checksum model state, at its reset values
   logic [2:0]       model_alg     = ALG_NONE;
   digest_stage_type model_stage   = STAGE_IDLE;
   logic [7:0]       model_fl_low  = 8'd0;
   logic [7:0]       model_fl_high = 8'd0;
   logic [31:0]      model_adler   = 32'd1;
   logic [31:0]      model_crc     = 32'hFFFF_FFFF;
   logic [7:0]       model_xor     = 8'd0;

   digest_reply_type pending_replies[$];
   int               mismatch_count = 0;
   int               requests_sent = 0;
   int               req_max_gap = 0;
   int               rsp_max_stall = 0;

   // Update the model for one accepted request and return the response it must give
   function automatic digest_reply_type predict_digest_reply(input logic [1:0] op,
                                                             input logic [7:0] b,
                                                             input logic [6:0] cap);
      digest_reply_type r;
      logic             alg_ok;
      logic [2:0]       need;
      int               lo;
      int               hi;
      int               a;
      int               s;
      logic [31:0]      c;
      r.status        = STATUS_REFUSED;
      r.digest_value  = 32'd0;
      r.digest_length = 3'd0;
      alg_ok = (model_alg <= ALG_XOR);
      case (op)
         OP_START: begin
            model_fl_low  = 8'd0;
            model_fl_high = 8'd0;
            model_adler   = 32'd1;
            model_crc     = 32'hFFFF_FFFF;
            model_xor     = 8'd0;
            model_stage   = alg_ok ? STAGE_OPEN : STAGE_IDLE;
            if (alg_ok) r.status = STATUS_OK;
         end
         OP_DATA: begin
            if ((model_stage == STAGE_OPEN || model_stage == STAGE_UPDATE) && alg_ok &&
                model_alg != ALG_NONE) begin
               case (model_alg)
                  ALG_FLETCHER: begin
                     lo = (int'(model_fl_low) + int'(b)) % int'(FLETCHER_MOD);
                     hi = (int'(model_fl_high) + lo) % int'(FLETCHER_MOD);
                     model_fl_low  = lo[7:0];
                     model_fl_high = hi[7:0];
                  end
                  ALG_ADLER: begin
                     a = (int'(model_adler[15:0]) + int'(b)) % int'(ADLER_MOD);
                     s = (int'(model_adler[31:16]) + a) % int'(ADLER_MOD);
                     model_adler = {s[15:0], a[15:0]};
                  end
                  ALG_CRC: begin
                     c = model_crc ^ {24'd0, b};
                     for (int k = 0; k < 8; k++) begin
                        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
                     end
                     model_crc = c;
                  end
                  default: model_xor = model_xor ^ b;
               endcase
               model_stage = STAGE_UPDATE;
               r.status = STATUS_OK;
            end
         end
         OP_FINISH: begin
            if (model_stage != STAGE_IDLE && alg_ok) begin
               case (model_alg)
                  ALG_FLETCHER: need = 3'd2;
                  ALG_ADLER:    need = 3'd4;
                  ALG_CRC:      need = 3'd4;
                  ALG_XOR:      need = 3'd1;
                  default:      need = 3'd0;
               endcase
               if (cap < need) begin
                  r.status = STATUS_SMALL;
               end else begin
                  r.status = STATUS_OK;
                  r.digest_length = need;
                  case (model_alg)
                     ALG_FLETCHER: r.digest_value = {16'd0, model_fl_high, model_fl_low};
                     ALG_ADLER:    r.digest_value = model_adler;
                     ALG_CRC:      r.digest_value = ~model_crc;
                     ALG_XOR:      r.digest_value = {24'd0, model_xor};
                     default:      r.digest_value = 32'd0;
                  endcase
                  model_stage = STAGE_FINAL;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // Send one request after a random gap; valid stays high when no gap follows
   task automatic issue_request(input logic [1:0] op, input logic [7:0] b,
                                input logic [6:0] cap);
      int gap;
      gap = $urandom_range(0, req_max_gap);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid           <= 1'b1;
      req_chan.operation       <= op;
      req_chan.data_byte       <= b;
      req_chan.buffer_capacity <= cap;
      do @(posedge clock); while (!req_chan.ready);
      pending_replies.push_back(predict_digest_reply(op, b, cap));
      requests_sent++;
   endtask

   // Stop sending and wait until every response has come back
   task automatic wait_for_idle();
      req_chan.valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write the algorithm register with the engine idle
   task automatic program_algorithm(input logic [2:0] alg);
      wait_for_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= alg;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      model_alg = alg;
   endtask

   // Out-of-order requests under the reset algorithm (none)
   task automatic test_idle_engine();
      issue_request(OP_FINISH, 8'h00, 7'd0);
      issue_request(OP_DATA, 8'hFF, 7'd127);
      issue_request(OP_UNKNOWN, 8'hFF, 7'd127);
      issue_request(OP_START, 8'h00, 7'd0);
      issue_request(OP_DATA, 8'h00, 7'd0);
      issue_request(OP_FINISH, 8'h00, 7'd0);
   endtask

   // Fletcher wrap at 255, short buffer, repeated finish, data after finish
   task automatic test_fletcher_sums();
      program_algorithm(ALG_FLETCHER);
      issue_request(OP_START, 8'h00, 7'd0);
      issue_request(OP_DATA, 8'hFF, 7'd0);
      issue_request(OP_DATA, 8'hFF, 7'd0);
      issue_request(OP_DATA, 8'h00, 7'd0);
      issue_request(OP_FINISH, 8'h00, 7'd1);
      issue_request(OP_FINISH, 8'h00, 7'd64);
      issue_request(OP_FINISH, 8'h00, 7'd2);
      issue_request(OP_DATA, 8'h01, 7'd2);
   endtask

   // CRC, Adler and XOR digests with capacities on both sides of the length
   task automatic test_other_sums();
      program_algorithm(ALG_CRC);
      issue_request(OP_START, 8'h00, 7'd0);
      issue_request(OP_DATA, 8'h80, 7'd0);
      issue_request(OP_FINISH, 8'h00, 7'd3);
      issue_request(OP_FINISH, 8'h00, 7'd127);
      program_algorithm(ALG_ADLER);
      issue_request(OP_START, 8'h00, 7'd0);
      issue_request(OP_DATA, 8'hFF, 7'd0);
      issue_request(OP_FINISH, 8'h00, 7'd4);
      program_algorithm(ALG_XOR);
      issue_request(OP_START, 8'h00, 7'd0);
      issue_request(OP_DATA, 8'h5A, 7'd0);
      issue_request(OP_FINISH, 8'h00, 7'd0);
      issue_request(OP_FINISH, 8'h00, 7'd1);
   endtask

   // Highest (undefined) algorithm code refuses everything
   task automatic test_invalid_codes();
      program_algorithm(ALG_INVALID);
      issue_request(OP_START, 8'h00, 7'd0);
      issue_request(OP_DATA, 8'h33, 7'd0);
      issue_request(OP_FINISH, 8'h00, 7'd127);
   endtask

   // Phases under random algorithms: mostly well-formed digests, some noise
   task automatic test_random_digests();
      int alg_pick;
      int n;
      int cap;
      while (requests_sent < RANDOM_REQUESTS) begin
         alg_pick = $urandom_range(0, 15);
         if (alg_pick > 7) alg_pick = $urandom_range(ALG_FLETCHER, ALG_XOR);
         program_algorithm(alg_pick[2:0]);
         req_max_gap   = ($urandom_range(0, 3) == 0) ? 0 : 5;
         rsp_max_stall = ($urandom_range(0, 3) == 0) ? 0 : 5;
         repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 7) == 0) begin
               issue_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                             7'($urandom_range(0, 127)));
            end else begin
               // occasionally carry on the previous digest without a start
               if ($urandom_range(0, 9) != 0)
                  issue_request(OP_START, 8'($urandom_range(0, 255)),
                                7'($urandom_range(0, 127)));
               n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
               repeat (n) issue_request(OP_DATA, 8'($urandom_range(0, 255)),
                                        7'($urandom_range(0, 127)));
               cap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) :
                                                   $urandom_range(0, 127);
               issue_request(OP_FINISH, 8'($urandom_range(0, 255)), 7'(cap));
               if ($urandom_range(0, 3) == 0)
                  issue_request(OP_FINISH, 8'($urandom_range(0, 255)),
                                7'($urandom_range(0, 127)));
               if ($urandom_range(0, 7) == 0)
                  issue_request(OP_DATA, 8'($urandom_range(0, 255)),
                                7'($urandom_range(0, 127)));
            end
         end
      end
   endtask

   // Response side: random stalls, each response checked against the oldest prediction
   initial begin
      int               stall;
      digest_reply_type want;
      rsp_chan.ready <= 1'b0;
      wait (reset == 1'b0);
      forever begin
         stall = $urandom_range(0, rsp_max_stall);
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         if (pending_replies.size() == 0) begin
            $display("%0t: unexpected response: status %0d value %h length %0d", $time,
                     rsp_chan.status, rsp_chan.digest_value, rsp_chan.digest_length);
            mismatch_count++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_chan.status !== want.status) begin
               $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                        want.status, rsp_chan.status);
               mismatch_count++;
            end
            if (rsp_chan.digest_value !== want.digest_value) begin
               $display("%0t: digest_value mismatch: expected %h, actual %h", $time,
                        want.digest_value, rsp_chan.digest_value);
               mismatch_count++;
            end
            if (rsp_chan.digest_length !== want.digest_length) begin
               $display("%0t: digest_length mismatch: expected %0d, actual %0d", $time,
                        want.digest_length, rsp_chan.digest_length);
               mismatch_count++;
            end
         end
      end
   end

   // Main sequence
   initial begin
      req_chan.valid           <= 1'b0;
      req_chan.operation       <= OP_START;
      req_chan.data_byte       <= 8'd0;
      req_chan.buffer_capacity <= 7'd0;
      csr_write_enable         <= 1'b0;
      csr_write_data           <= ALG_NONE;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_idle_engine();
      test_fletcher_sums();
      test_other_sums();
      test_invalid_codes();
      test_random_digests();
      wait_for_idle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

### files.f
sv/mce_pkg.sv
sv/mce_req_if.sv
sv/mce_rsp_if.sv
sv/mce_front.sv
sv/mce_queue.sv
sv/mce_back.sv
sv/multi_checksum_engine.sv
tb/sv/multi_checksum_engine_test.sv
